FILE: design/vsp_pkg.sv
`default_nettype none

package vsp_pkg;

  // Operation codes carried in the command field of a request.
  typedef enum logic [4:0] {
    CMD_PSRLDQ    = 5'd0,
    CMD_PSLLDQ    = 5'd1,
    CMD_PSRLW     = 5'd2,
    CMD_PSLLW     = 5'd3,
    CMD_PSRAW     = 5'd4,
    CMD_PSRLD     = 5'd5,
    CMD_PSLLD     = 5'd6,
    CMD_PSRLQ     = 5'd7,
    CMD_PSLLQ     = 5'd8,
    CMD_INSERT    = 5'd9,
    CMD_EXTRACT   = 5'd10,
    CMD_BCASTB    = 5'd11,
    CMD_BCASTW    = 5'd12,
    CMD_BCASTD    = 5'd13,
    CMD_BCASTQ    = 5'd14,
    CMD_PERM2X128 = 5'd15,
    CMD_PERMD     = 5'd16,
    CMD_PERMQ     = 5'd17
  } vsp_cmd_t;

  // Counts at or above these limits clear the element or lane.
  localparam logic [7:0] LANE_BYTES = 8'd16;
  localparam logic [7:0] WORD_BITS  = 8'd16;
  localparam logic [7:0] DWORD_BITS = 8'd32;
  localparam logic [7:0] QWORD_BITS = 8'd64;

  // Largest useful arithmetic word shift.
  localparam logic [3:0] SRAW_MAX = 4'd15;

  typedef struct packed {
    logic [4:0]  command;
    logic [63:0] first_word0;
    logic [63:0] first_word1;
    logic [63:0] first_word2;
    logic [63:0] first_word3;
    logic [63:0] second_word0;
    logic [63:0] second_word1;
    logic [63:0] second_word2;
    logic [63:0] second_word3;
    logic [7:0]  immediate;
  } vsp_request_t;

  typedef struct packed {
    logic [63:0] result_word0;
    logic [63:0] result_word1;
    logic [63:0] result_word2;
    logic [63:0] result_word3;
    logic        unsupported;
  } vsp_result_t;

  // Output of one execution unit: its value and whether it owns the command.
  typedef struct packed {
    logic [255:0] value;
    logic         hit;
  } vsp_unit_out_t;

endpackage

`default_nettype wire

FILE: design/vsp_shift_unit.sv
`default_nettype none

module vsp_shift_unit
  import vsp_pkg::*;
(
  input  wire logic [4:0]   command,
  input  wire logic [255:0] first_src,
  input  wire logic [7:0]   immediate,
  output vsp_unit_out_t     unit_out
);

  // Lane byte shifts and element shifts, all taken from the first source.
  always_comb begin
    logic [3:0] sraw_count;
    sraw_count = (immediate > 8'(SRAW_MAX)) ? SRAW_MAX : immediate[3:0];
    unit_out.value = '0;
    unit_out.hit   = 1'b1;
    case (vsp_cmd_t'(command))
      CMD_PSRLDQ: begin
        for (int l = 0; l < 2; l++) begin
          unit_out.value[128*l +: 128] = (immediate >= LANE_BYTES) ? 128'd0 :
              first_src[128*l +: 128] >> {immediate[3:0], 3'b000};
        end
      end
      CMD_PSLLDQ: begin
        for (int l = 0; l < 2; l++) begin
          unit_out.value[128*l +: 128] = (immediate >= LANE_BYTES) ? 128'd0 :
              first_src[128*l +: 128] << {immediate[3:0], 3'b000};
        end
      end
      CMD_PSRLW: begin
        for (int i = 0; i < 16; i++) begin
          unit_out.value[16*i +: 16] = (immediate >= WORD_BITS) ? 16'd0 :
              first_src[16*i +: 16] >> immediate[3:0];
        end
      end
      CMD_PSLLW: begin
        for (int i = 0; i < 16; i++) begin
          unit_out.value[16*i +: 16] = (immediate >= WORD_BITS) ? 16'd0 :
              first_src[16*i +: 16] << immediate[3:0];
        end
      end
      CMD_PSRAW: begin
        for (int i = 0; i < 16; i++) begin
          unit_out.value[16*i +: 16] = 16'($signed(first_src[16*i +: 16]) >>> sraw_count);
        end
      end
      CMD_PSRLD: begin
        for (int i = 0; i < 8; i++) begin
          unit_out.value[32*i +: 32] = (immediate >= DWORD_BITS) ? 32'd0 :
              first_src[32*i +: 32] >> immediate[4:0];
        end
      end
      CMD_PSLLD: begin
        for (int i = 0; i < 8; i++) begin
          unit_out.value[32*i +: 32] = (immediate >= DWORD_BITS) ? 32'd0 :
              first_src[32*i +: 32] << immediate[4:0];
        end
      end
      CMD_PSRLQ: begin
        for (int i = 0; i < 4; i++) begin
          unit_out.value[64*i +: 64] = (immediate >= QWORD_BITS) ? 64'd0 :
              first_src[64*i +: 64] >> immediate[5:0];
        end
      end
      CMD_PSLLQ: begin
        for (int i = 0; i < 4; i++) begin
          unit_out.value[64*i +: 64] = (immediate >= QWORD_BITS) ? 64'd0 :
              first_src[64*i +: 64] << immediate[5:0];
        end
      end
      default: begin
        unit_out.hit = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/vsp_permute_unit.sv
`default_nettype none

module vsp_permute_unit
  import vsp_pkg::*;
(
  input  wire logic [4:0]   command,
  input  wire logic [255:0] first_src,
  input  wire logic [255:0] second_src,
  input  wire logic [7:0]   immediate,
  output vsp_unit_out_t     unit_out
);

  // Half moves, broadcasts and permutes.
  always_comb begin
    logic [3:0]   half_sel;
    logic [255:0] half_src;
    logic [2:0]   dword_idx;
    logic [1:0]   qword_idx;
    half_sel       = '0;
    half_src       = '0;
    dword_idx      = '0;
    qword_idx      = '0;
    unit_out.value = '0;
    unit_out.hit   = 1'b1;
    case (vsp_cmd_t'(command))
      CMD_INSERT: begin
        unit_out.value = first_src;
        unit_out.value[{immediate[0], 7'b0000000} +: 128] = second_src[127:0];
      end
      CMD_EXTRACT: begin
        unit_out.value[127:0] = first_src[{immediate[0], 7'b0000000} +: 128];
      end
      CMD_BCASTB: unit_out.value = {32{second_src[7:0]}};
      CMD_BCASTW: unit_out.value = {16{second_src[15:0]}};
      CMD_BCASTD: unit_out.value = {8{second_src[31:0]}};
      CMD_BCASTQ: unit_out.value = {4{second_src[63:0]}};
      CMD_PERM2X128: begin
        // Each result half picks one of four source halves, or zero.
        for (int h = 0; h < 2; h++) begin
          half_sel = immediate[4*h +: 4];
          half_src = half_sel[1] ? second_src : first_src;
          unit_out.value[128*h +: 128] = half_sel[3] ? 128'd0 :
              half_src[{half_sel[0], 7'b0000000} +: 128];
        end
      end
      CMD_PERMD: begin
        // Indices come from the low bits of each first-source dword.
        for (int i = 0; i < 8; i++) begin
          dword_idx = first_src[32*i +: 3];
          unit_out.value[32*i +: 32] = second_src[{dword_idx, 5'b00000} +: 32];
        end
      end
      CMD_PERMQ: begin
        for (int i = 0; i < 4; i++) begin
          qword_idx = immediate[2*i +: 2];
          unit_out.value[64*i +: 64] = second_src[{qword_idx, 6'b000000} +: 64];
        end
      end
      default: begin
        unit_out.hit = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/vector_shift_permute_unit.sv
// Vector shift and permute unit for 256-bit operands.
// A request carries a command, two 256-bit sources as four 64-bit words each
// and an 8-bit immediate; every request gives exactly one result: four 64-bit
// words and an unsupported flag, which is set, with a zero value, for unknown
// commands.
// Both channels use valid and stall: a transfer happens at a rising edge with
// valid high and stall low. Requests enter an input register, the operation is
// evaluated combinationally by the shift and permute units and stored in the
// result register.
// A request passes through the input register and then the result register;
// one request is accepted and one result delivered per cycle while unstalled.
// When the receiver stalls, the result is held and the input register still
// accepts one more request; request_stall rises only once both are full.
// A synchronous, active-high reset empties both registers; data stays as is.
`default_nettype none

module vector_shift_permute_unit
  import vsp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         request_valid,
  output logic              request_stall,
  input  wire vsp_request_t request,
  output logic              result_valid,
  input  wire logic         result_stall,
  output vsp_result_t       result
);

  logic          stage_valid;
  vsp_request_t  stage_request;
  logic          result_load;
  logic          stage_load;
  logic [255:0]  first_src;
  logic [255:0]  second_src;
  vsp_unit_out_t shift_out;
  vsp_unit_out_t permute_out;
  logic [255:0]  value_next;
  logic          unsupported_next;

  // Flow control: each register loads when it is empty or its content moves on.
  assign result_load   = !result_valid || !result_stall;
  assign stage_load    = !stage_valid || result_load;
  assign request_stall = !stage_load;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_load) begin
      stage_valid <= request_valid;
    end
    if (stage_load && request_valid) begin
      stage_request <= request;
    end
  end

  assign first_src  = {stage_request.first_word3, stage_request.first_word2,
                       stage_request.first_word1, stage_request.first_word0};
  assign second_src = {stage_request.second_word3, stage_request.second_word2,
                       stage_request.second_word1, stage_request.second_word0};

  vsp_shift_unit u_shift (
    .command   (stage_request.command),
    .first_src (first_src),
    .immediate (stage_request.immediate),
    .unit_out  (shift_out)
  );

  vsp_permute_unit u_permute (
    .command    (stage_request.command),
    .first_src  (first_src),
    .second_src (second_src),
    .immediate  (stage_request.immediate),
    .unit_out   (permute_out)
  );

  // Only the owning unit drives a non-zero value, so the two are merged by OR.
  assign value_next       = shift_out.value | permute_out.value;
  assign unsupported_next = !(shift_out.hit || permute_out.hit);

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= stage_valid;
    end
    if (result_load && stage_valid) begin
      result.result_word0 <= value_next[63:0];
      result.result_word1 <= value_next[127:64];
      result.result_word2 <= value_next[191:128];
      result.result_word3 <= value_next[255:192];
      result.unsupported  <= unsupported_next;
    end
  end

endmodule

`default_nettype wire
